// ----- rtl/ipu_pkg.sv -----
// Shared types and constants of the integer point upscaler.
// Used by the controller, the datapath and the top level.
package ipu_pkg;

    localparam int SCALE_W = 4;           // scale_factor register width
    localparam int DIM_W   = 12;          // image_width / image_height register width
    localparam int LINE_W  = 3;           // copy and line counters inside one block
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 30;
    localparam int IDX_W   = ADDR_W - 1;  // pixel index, enough for the 2-byte mode
    localparam int CFG_IDX_W = 2;

    localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd1;
    localparam logic [DIM_W-1:0]   WIDTH_RST  = 12'd320;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 12'd200;
    localparam logic               MODE_RST   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_MODE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_BASE,
        ST_EMIT
    } ipu_state_t;

    typedef struct packed {
        logic load;   // take the input word, step the position counters
        logic mul1;   // pitch, row*scale, column*scale
        logic mul2;   // row offset = row*scale*pitch
        logic base;   // block start index, clear block counters
        logic emit;   // load the output register and step through the block
    } ipu_cmd_t;

    typedef struct packed {
        logic out_free;  // output register empty or being taken
        logic blk_last;  // current write is the last of the block
    } ipu_stat_t;

endpackage

// ----- rtl/ipu_ctrl.sv -----
// Controller of the integer point upscaler: sequences setup and block writes.
// Depends on ipu_pkg.
module ipu_ctrl import ipu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ipu_stat_t stat,
    output ipu_cmd_t  cmd
);

    ipu_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_BASE;
            ST_BASE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free && stat.blk_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_BASE: cmd.base = 1'b1;
            ST_EMIT: cmd.emit = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- rtl/ipu_datapath.sv -----
// Datapath of the integer point upscaler: position counters, address
// arithmetic and the output register. Depends on ipu_pkg.
module ipu_datapath import ipu_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [SCALE_W-1:0] scale_eff,
    input  logic [WW-1:0]      width_eff,
    input  logic [HW-1:0]      height_eff,
    input  logic               pixel_mode,
    input  logic [PIX_W-1:0]   pixel_in,
    input  logic               frame_start,
    input  ipu_cmd_t           cmd,
    output ipu_stat_t          stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ADDR_W-1:0]  dest_byte_address,
    output logic [PIX_W-1:0]   pixel_out,
    output logic               last_copy,
    output logic               frame_done
);

    localparam int PW  = WW + SCALE_W;   // pitch in pixels
    localparam int RSW = RW + SCALE_W;   // row * scale
    localparam int CSW = CW + SCALE_W;   // column * scale
    localparam int PRW = RSW + PW;

    // position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // current item
    logic [CW-1:0]    item_col_reg;
    logic [RW-1:0]    item_row_reg;
    logic [PIX_W-1:0] item_pix_reg;
    logic             item_fend_reg;

    logic [PW-1:0]    pitch_reg;
    logic [RSW-1:0]   row_s_reg;
    logic [CSW-1:0]   col_s_reg;
    logic [PRW-1:0]   prod_reg;
    logic [IDX_W-1:0] line_base_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [LINE_W-1:0] cpy_reg;
    logic [LINE_W-1:0] line_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic [CW-1:0]   cur_col;
    logic [RW-1:0]   cur_row;
    logic            row_end, frame_end;
    logic            cpy_end, line_end;
    logic [IDX_W-1:0] pitch_idx;

    assign cur_col   = frame_start ? '0 : col_reg;
    assign cur_row   = frame_start ? '0 : row_reg;
    assign row_end   = ((WW + 1)'(cur_col) + (WW + 1)'(1)) >= (WW + 1)'(width_eff);
    assign frame_end = row_end &&
                       (((HW + 1)'(cur_row) + (HW + 1)'(1)) >= (HW + 1)'(height_eff));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load) begin
            if (row_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : cur_row + RW'(1);
            end else begin
                col_next = cur_col + CW'(1);
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign cpy_end   = ({1'b0, cpy_reg}  + SCALE_W'(1)) == scale_eff;
    assign line_end  = ({1'b0, line_reg} + SCALE_W'(1)) == scale_eff;
    assign pitch_idx = IDX_W'(pitch_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_col_reg  <= cur_col;
            item_row_reg  <= cur_row;
            item_fend_reg <= frame_end;
            item_pix_reg  <= pixel_mode ? pixel_in : {16'h0000, pixel_in[15:0]};
        end
        if (cmd.mul1) begin
            pitch_reg <= width_eff * scale_eff;
            row_s_reg <= item_row_reg * scale_eff;
            col_s_reg <= item_col_reg * scale_eff;
        end
        if (cmd.mul2) begin
            prod_reg <= row_s_reg * pitch_reg;
        end
        if (cmd.base) begin
            line_base_reg <= IDX_W'(prod_reg) + IDX_W'(col_s_reg);
            cur_idx_reg   <= IDX_W'(prod_reg) + IDX_W'(col_s_reg);
            cpy_reg       <= '0;
            line_reg      <= '0;
        end
        if (cmd.emit) begin
            out_addr_reg <= pixel_mode ? {cur_idx_reg[ADDR_W-3:0], 2'b00}
                                       : {cur_idx_reg, 1'b0};
            out_pix_reg  <= item_pix_reg;
            out_last_reg <= cpy_end && line_end;
            out_done_reg <= cpy_end && line_end && item_fend_reg;
            // advance along the line, or drop to the start of the next line
            if (cpy_end) begin
                cpy_reg       <= '0;
                line_reg      <= line_reg + LINE_W'(1);
                line_base_reg <= line_base_reg + pitch_idx;
                cur_idx_reg   <= line_base_reg + pitch_idx;
            end else begin
                cpy_reg     <= cpy_reg + LINE_W'(1);
                cur_idx_reg <= cur_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.blk_last = cpy_end && line_end;

    assign m_tvalid          = out_valid_reg;
    assign dest_byte_address = out_addr_reg;
    assign pixel_out         = out_pix_reg;
    assign last_copy         = out_last_reg;
    assign frame_done        = out_done_reg;

endmodule

// ----- rtl/integer_point_upscaler.sv -----
// Top level of the integer point upscaler: configuration registers and
// limits, controller and datapath. Depends on ipu_pkg, ipu_ctrl, ipu_datapath.
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | source pixel word, frame start in tuser
//  m_      | out | m_tvalid/m_tready  | one buffer write: address, pixel, flags
//  cfg_    | in  | cfg_valid/cfg_ready| register index and write data
//
// Each input word is taken in the idle state, then passes the setup steps
// (pitch and row offset multiplies, block start) and scale*scale buffer writes,
// one buffer write per cycle while the output does not stall. The next word
// is taken while the last write of the previous one still sits in the output
// register. Output stalls hold the write sequence. Synchronous active-low reset
// clears the position counters and loads the register defaults; the config port
// is always ready.
module integer_point_upscaler import ipu_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_SCALE  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] pixel_in
    input  logic [0:0]           s_tuser,   // [0] frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // [29:0] dest_byte_address, [61:30] pixel_out
    output logic                 m_tlast,   // last_copy
    output logic [0:0]           m_tuser,   // [0] frame_done
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               mode_reg;

    logic [SCALE_W-1:0] scale_eff;
    logic [WW-1:0]      width_eff;
    logic [HW-1:0]      height_eff;

    ipu_cmd_t          cmd;
    ipu_stat_t         stat;
    logic [ADDR_W-1:0] dest_addr;
    logic [PIX_W-1:0]  pix_out;
    logic              done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            mode_reg   <= MODE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero reads as one, anything above the limit saturates
    always_comb begin
        if (scale_reg == '0) begin
            scale_eff = SCALE_W'(1);
        end else if ((SCALE_W + 1)'(scale_reg) > (SCALE_W + 1)'(MAX_SCALE)) begin
            scale_eff = SCALE_W'(MAX_SCALE);
        end else begin
            scale_eff = scale_reg;
        end
        if (width_reg == '0) begin
            width_eff = WW'(1);
        end else if ((DIM_W + 2)'(width_reg) > (DIM_W + 2)'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            height_eff = HW'(1);
        end else if ((DIM_W + 2)'(height_reg) > (DIM_W + 2)'(MAX_HEIGHT)) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(height_reg);
        end
    end

    ipu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ipu_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .scale_eff         (scale_eff),
        .width_eff         (width_eff),
        .height_eff        (height_eff),
        .pixel_mode        (mode_reg),
        .pixel_in          (s_tdata),
        .frame_start       (s_tuser[0]),
        .cmd               (cmd),
        .stat              (stat),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .dest_byte_address (dest_addr),
        .pixel_out         (pix_out),
        .last_copy         (m_tlast),
        .frame_done        (done)
    );

    assign m_tdata = {2'b00, pix_out, dest_addr};
    assign m_tuser = done;

endmodule
